### hw/rtl/tofp_pkg.sv
// shared types and constants for the distance frame parser
`timescale 1ns / 1ps

package tofp_pkg;

    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 32;
    localparam int CLK_W    = 30;
    localparam int DIST_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int PERIOD_W = 23;
    localparam int MS_W     = 10;
    localparam int NUM_W    = 42;
    localparam int WIN_DEPTH = 5;
    localparam int FILL_W   = 3;
    localparam int STEP_W   = 5;

    localparam logic [BYTE_W-1:0]   HDR_FIRST   = 8'h03;
    localparam logic [BYTE_W-1:0]   HDR_SECOND  = 8'h02;
    localparam logic [MS_W-1:0]     MS_PER_S    = 10'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 23'h7F_FFFF;
    localparam logic [CLK_W-1:0]    CLOCK_RESET = 30'd100_000_000;
    localparam logic [STEP_W-1:0]   DIV_LAST    = 5'd22;
    localparam logic [FILL_W-1:0]   FILL_FULL   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_OUT
    } tofp_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADD,
        PH_CHK,
        PH_DIV,
        PH_DONE
    } tofp_phase_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] delta;
    } tofp_per_req_t;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] period;
    } tofp_per_rsp_t;

endpackage

### hw/rtl/tofp_period_unit.sv
// tick delta to rounded milliseconds: multiply, round, 23-step restoring divide
`timescale 1ns / 1ps

module tofp_period_unit
    import tofp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CLK_W-1:0]    clk_hz,
    input  tofp_per_req_t       req,
    output tofp_per_rsp_t       rsp
);

    tofp_phase_t         phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [CLK_W-1:0]    rem_reg, rem_next;
    logic [PERIOD_W-1:0] quo_reg, quo_next;
    logic                sat_reg, sat_next;
    logic [CLK_W:0]      trial;
    logic [CLK_W:0]      divisor;
    logic                qbit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (req.start) phase_next = PH_ADD;
            end
            PH_ADD:  phase_next = PH_CHK;
            PH_CHK:  phase_next = PH_DIV;
            PH_DIV: begin
                if (step_reg == DIV_LAST) phase_next = PH_DONE;
            end
            PH_DONE: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        step_next = step_reg;
        divisor   = {1'b0, clk_hz};
        trial     = {rem_reg, num_reg[PERIOD_W-1]};
        qbit      = (trial >= divisor);
        case (phase_reg)
            PH_IDLE: begin
                if (req.start) begin
                    num_next = NUM_W'(req.delta) * NUM_W'(MS_PER_S);
                end
            end
            PH_ADD: begin
                num_next = num_reg + NUM_W'(clk_hz >> 1);
            end
            PH_CHK: begin
                // quotient overflows 23 bits exactly when the top part reaches the divisor
                rem_next  = CLK_W'(num_reg[NUM_W-1:PERIOD_W]);
                sat_next  = (CLK_W'(num_reg[NUM_W-1:PERIOD_W]) >= clk_hz);
                quo_next  = '0;
                step_next = '0;
            end
            PH_DIV: begin
                if (qbit) begin
                    rem_next = CLK_W'(trial - divisor);
                end else begin
                    rem_next = CLK_W'(trial);
                end
                quo_next = {quo_reg[PERIOD_W-2:0], qbit};
                num_next = {num_reg[NUM_W-1:PERIOD_W], num_reg[PERIOD_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
            end
            PH_DONE: begin
                step_next = '0;
            end
            default: begin
                step_next = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        rsp.done   = (phase_reg == PH_DONE);
        rsp.period = sat_reg ? PERIOD_MAX : quo_reg;
    end

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> phase_reg == PH_IDLE)
        else $error("period unit started while busy");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DIV |-> step_reg <= DIV_LAST)
        else $error("divide step counter out of range");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done)
        else $error("done held for more than one cycle");

endmodule

### hw/rtl/tof_distance_frame_parser_core.sv
// top level: byte window, header search, frame bookkeeping and result register
`timescale 1ns / 1ps
// a byte that completes no frame keeps the core in ST_IDLE; s_ready stays high
// first frame after reset: ST_IDLE goes straight to ST_OUT, which loads the result word once
//   the output register is free; later frames first pass through ST_CALC while the restoring
//   divider in the period unit works (mul, round, range check, 23 divide steps, done, load);
//   in either case no byte is taken until the result word is loaded
// result word sits in an output register, so the next byte can be taken while it waits
// aresetn (sync, active low) empties the window, clears count, period and frame history,
//   and sets core_clock_hz to 100 MHz

module tof_distance_frame_parser_core
    import tofp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // configuration: core_clock_hz
    input  logic                cfg_wr_en,
    input  logic [CLK_W-1:0]    cfg_wr_data,

    // received byte stream
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_rx_byte,
    input  logic [TICK_W-1:0]   s_timestamp_ticks,

    // accepted frames
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DIST_W-1:0]   m_distance_mm,
    output logic [COUNT_W-1:0]  m_update_count,
    output logic [PERIOD_W-1:0] m_period_ms,
    output logic                m_send_request
);

    // control state
    tofp_state_t         state_reg, state_next;
    logic [FILL_W-1:0]   window_fill_reg, window_fill_next;
    logic                have_frame_reg, have_frame_next;
    logic [COUNT_W-1:0]  frame_total_reg, frame_total_next;
    logic [PERIOD_W-1:0] last_period_reg, last_period_next;
    logic [CLK_W-1:0]    core_clock_hz_reg;
    logic                m_valid_reg;

    // payload state
    logic [BYTE_W-1:0]   window_reg [WIN_DEPTH];
    logic [BYTE_W-1:0]   window_next [WIN_DEPTH];
    logic [TICK_W-1:0]   last_ticks_reg, last_ticks_next;
    logic [DIST_W-1:0]   dist_hold_reg, dist_hold_next;
    logic [DIST_W-1:0]   m_distance_mm_reg;
    logic [COUNT_W-1:0]  m_update_count_reg;
    logic [PERIOD_W-1:0] m_period_ms_reg;

    // window with the incoming byte dropped into the next free slot
    logic [BYTE_W-1:0]   win_full [WIN_DEPTH];
    logic                s_fire;
    logic                full_now;
    logic                hdr_at_1;
    logic                hdr_at_2;
    logic                hdr_at_3;
    logic                frame_hit;
    logic                out_load;

    tofp_per_req_t       per_req;
    tofp_per_rsp_t       per_rsp;

    tofp_period_unit u_period (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clk_hz  (core_clock_hz_reg),
        .req     (per_req),
        .rsp     (per_rsp)
    );

    assign s_fire   = s_valid && s_ready;
    assign full_now = (window_fill_reg == FILL_FULL);

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_full[i] = (FILL_W'(i) == window_fill_reg) ? s_rx_byte : window_reg[i];
        end
    end

    // header search over the full window; only meaningful when the fifth byte arrives
    assign hdr_at_1  = (win_full[1] == HDR_FIRST) && (win_full[2] == HDR_SECOND);
    assign hdr_at_2  = (win_full[2] == HDR_FIRST) && (win_full[3] == HDR_SECOND);
    assign hdr_at_3  = (win_full[3] == HDR_FIRST) && (win_full[4] == HDR_SECOND);
    assign frame_hit = s_fire && full_now && hdr_at_1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (frame_hit) begin
                    // first frame has no earlier timestamp, period stays as is
                    state_next = have_frame_reg ? ST_CALC : ST_OUT;
                end
            end
            ST_CALC: begin
                if (per_rsp.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready       = 1'b0;
        per_req.start = 1'b0;
        // tick difference wraps modulo 2^32
        per_req.delta = s_timestamp_ticks - last_ticks_reg;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                per_req.start = frame_hit && have_frame_reg;
            end
            ST_CALC: begin
                s_ready = 1'b0;
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // window, frame bookkeeping
    always_comb begin
        window_next      = window_reg;
        window_fill_next = window_fill_reg;
        have_frame_next  = have_frame_reg;
        frame_total_next = frame_total_reg;
        last_ticks_next  = last_ticks_reg;
        last_period_next = last_period_reg;
        dist_hold_next   = dist_hold_reg;

        if (s_fire) begin
            if (!full_now) begin
                window_next      = win_full;
                window_fill_next = window_fill_reg + 1'b1;
            end else if (hdr_at_1) begin
                // frame accepted: big-endian distance from bytes 3 and 4
                dist_hold_next   = {win_full[3], win_full[4]};
                frame_total_next = frame_total_reg + 1'b1;
                last_ticks_next  = s_timestamp_ticks;
                have_frame_next  = 1'b1;
                window_fill_next = '0;
            end else if (hdr_at_2) begin
                // resync: keep bytes 1..4
                window_next[0]   = win_full[1];
                window_next[1]   = win_full[2];
                window_next[2]   = win_full[3];
                window_next[3]   = win_full[4];
                window_fill_next = 3'd4;
            end else if (hdr_at_3) begin
                // resync: keep bytes 2..4
                window_next[0]   = win_full[2];
                window_next[1]   = win_full[3];
                window_next[2]   = win_full[4];
                window_fill_next = 3'd3;
            end else begin
                // no header anywhere: keep the last two bytes
                window_next[0]   = win_full[3];
                window_next[1]   = win_full[4];
                window_fill_next = 3'd2;
            end
        end

        if (state_reg == ST_CALC && per_rsp.done) begin
            last_period_next = per_rsp.period;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            window_fill_reg   <= '0;
            have_frame_reg    <= 1'b0;
            frame_total_reg   <= '0;
            last_period_reg   <= '0;
            core_clock_hz_reg <= CLOCK_RESET;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            window_fill_reg <= window_fill_next;
            have_frame_reg  <= have_frame_next;
            frame_total_reg <= frame_total_next;
            last_period_reg <= last_period_next;
            if (cfg_wr_en) begin
                core_clock_hz_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        window_reg     <= window_next;
        last_ticks_reg <= last_ticks_next;
        dist_hold_reg  <= dist_hold_next;
        if (out_load) begin
            m_distance_mm_reg  <= dist_hold_reg;
            m_update_count_reg <= frame_total_reg;
            m_period_ms_reg    <= last_period_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_distance_mm  = m_distance_mm_reg;
    assign m_update_count = m_update_count_reg;
    assign m_period_ms    = m_period_ms_reg;
    // m_send_request is tied high: a distance poll is always requested, not only after accepted frames
    assign m_send_request = 1'b1;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        window_fill_reg <= FILL_FULL)
        else $error("window fill beyond four stored bytes");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        per_rsp.done |-> state_reg == ST_CALC)
        else $error("period result arrived outside calc state");

    a_calc_needs_history: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CALC |-> have_frame_reg)
        else $error("period computed with no earlier frame");

endmodule
